// ===== hw/rtl/vgd_pkg.sv =====
// Shared types, code points and glyph codes for the Vietnamese UTF-8 glyph decoder.
`timescale 1ns / 1ps

package vgd_pkg;

	// Vowel mark codes
	localparam logic [2:0] MARK_NONE       = 3'd0;
	localparam logic [2:0] MARK_BREVE      = 3'd1;
	localparam logic [2:0] MARK_CIRCUMFLEX = 3'd2;
	localparam logic [2:0] MARK_HORN       = 3'd3;
	localparam logic [2:0] MARK_BAR        = 3'd4;

	// Tone codes
	localparam logic [2:0] TONE_NONE  = 3'd0;
	localparam logic [2:0] TONE_GRAVE = 3'd1;
	localparam logic [2:0] TONE_ACUTE = 3'd2;
	localparam logic [2:0] TONE_HOOK  = 3'd3;
	localparam logic [2:0] TONE_TILDE = 3'd4;
	localparam logic [2:0] TONE_DOT   = 3'd5;

	// Base character used for anything that has no mapping
	localparam logic [6:0] CH_QUESTION = 7'h3F;
	localparam logic [15:0] CP_QUESTION = 16'h003F;

	// Combining code points
	localparam logic [15:0] CP_COMB_GRAVE      = 16'h0300;
	localparam logic [15:0] CP_COMB_ACUTE      = 16'h0301;
	localparam logic [15:0] CP_COMB_CIRCUMFLEX = 16'h0302;
	localparam logic [15:0] CP_COMB_TILDE      = 16'h0303;
	localparam logic [15:0] CP_COMB_BREVE      = 16'h0306;
	localparam logic [15:0] CP_COMB_HOOK       = 16'h0309;
	localparam logic [15:0] CP_COMB_HORN       = 16'h031B;
	localparam logic [15:0] CP_COMB_DOT        = 16'h0323;

	// Ranges of precomposed letters: each spans eight code points, even ones upper case.
	localparam int NUM_RANGES = 6;
	localparam logic [15:0] RANGE_START [NUM_RANGES] = '{
		16'h1EB0, 16'h1EA6, 16'h1EC0, 16'h1ED2, 16'h1EDC, 16'h1EEA
	};
	localparam logic [6:0] RANGE_BASE [NUM_RANGES] = '{
		7'h41, 7'h41, 7'h45, 7'h4F, 7'h4F, 7'h55
	};
	localparam logic [2:0] RANGE_MARK [NUM_RANGES] = '{
		MARK_BREVE, MARK_CIRCUMFLEX, MARK_CIRCUMFLEX,
		MARK_CIRCUMFLEX, MARK_HORN, MARK_HORN
	};
	localparam logic [2:0] RANGE_TONE [4] = '{TONE_GRAVE, TONE_HOOK, TONE_TILDE, TONE_DOT};

	typedef struct packed {
		logic [6:0] base;
		logic [2:0] mark;
		logic [2:0] tone;
	} glyph_t;

	// What the byte assembler reports for the item it is handed
	typedef struct packed {
		logic        flush;
		logic        complete;
		logic [15:0] cp;
	} asm_t;

	function automatic glyph_t mk_glyph(logic [6:0] base, logic [2:0] mark, logic [2:0] tone);
		glyph_t g;
		g.base = base;
		g.mark = mark;
		g.tone = tone;
		return g;
	endfunction

endpackage

// ===== hw/rtl/vgd_utf8_assembler.sv =====
// UTF-8 byte assembler: gathers lead and continuation bytes into code points.
`timescale 1ns / 1ps

module vgd_utf8_assembler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   text_byte,
	input  logic         end_of_text,
	output vgd_pkg::asm_t res
);

	logic [9:0]  partial_q;
	logic [1:0]  due_q;
	logic [9:0]  partial_nxt;
	logic [1:0]  due_nxt;
	logic [15:0] cp_cont;

	assign cp_cont = {partial_q, text_byte[5:0]};

	always_comb begin
		res.flush    = end_of_text || (text_byte == 8'h00);
		res.complete = 1'b0;
		res.cp       = 16'h0000;
		partial_nxt  = partial_q;
		due_nxt      = due_q;
		if (res.flush) begin
			partial_nxt = 10'h000;
			due_nxt     = 2'd0;
		end else if (due_q != 2'd0) begin
			due_nxt = due_q - 2'd1;
			if (due_q == 2'd1) begin
				res.complete = 1'b1;
				res.cp       = cp_cont;
				partial_nxt  = 10'h000;
			end else begin
				partial_nxt = cp_cont[9:0];
			end
		end else if (!text_byte[7]) begin
			res.complete = 1'b1;
			res.cp       = {8'h00, text_byte};
		end else if (text_byte[7:5] == 3'b110) begin
			partial_nxt = {5'h00, text_byte[4:0]};
			due_nxt     = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			partial_nxt = {6'h00, text_byte[3:0]};
			due_nxt     = 2'd2;
		end else begin
			// Stray continuation, lead of four or more bytes, or invalid byte
			res.complete = 1'b1;
			res.cp       = vgd_pkg::CP_QUESTION;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 10'h000;
			due_q     <= 2'd0;
		end else if (step) begin
			partial_q <= partial_nxt;
			due_q     <= due_nxt;
		end
	end

endmodule

// ===== hw/rtl/vgd_glyph_map.sv =====
// Glyph map: turns a code point into base letter, vowel mark and tone.
`timescale 1ns / 1ps

module vgd_glyph_map (
	input  logic [15:0]    cp,
	output vgd_pkg::glyph_t glyph
);

	logic           hit;
	vgd_pkg::glyph_t letter;
	logic           range_hit;
	vgd_pkg::glyph_t range_glyph;
	logic [15:0]    off;

	// Fixed table of precomposed letters
	always_comb begin
		hit    = 1'b1;
		letter = vgd_pkg::mk_glyph(vgd_pkg::CH_QUESTION, vgd_pkg::MARK_NONE, vgd_pkg::TONE_NONE);
		case (cp)
			16'h00C0: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00C1: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EA2: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h00C3: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EA0: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h0102: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_BREVE, vgd_pkg::TONE_NONE);
			16'h00C2: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h1EAE: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_BREVE, vgd_pkg::TONE_ACUTE);
			16'h1EA4: letter = vgd_pkg::mk_glyph(7'h41, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h00E0: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00E1: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EA3: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h00E3: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EA1: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h0103: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_BREVE, vgd_pkg::TONE_NONE);
			16'h00E2: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h1EAF: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_BREVE, vgd_pkg::TONE_ACUTE);
			16'h1EA5: letter = vgd_pkg::mk_glyph(7'h61, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h0110: letter = vgd_pkg::mk_glyph(7'h44, vgd_pkg::MARK_BAR, vgd_pkg::TONE_NONE);
			16'h0111: letter = vgd_pkg::mk_glyph(7'h64, vgd_pkg::MARK_BAR, vgd_pkg::TONE_NONE);
			16'h00C8: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00C9: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EBA: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h1EBC: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EB8: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00CA: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h1EBE: letter = vgd_pkg::mk_glyph(7'h45, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h00E8: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00E9: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EBB: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h1EBD: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EB9: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00EA: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h1EBF: letter = vgd_pkg::mk_glyph(7'h65, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h00CC: letter = vgd_pkg::mk_glyph(7'h49, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00CD: letter = vgd_pkg::mk_glyph(7'h49, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EC8: letter = vgd_pkg::mk_glyph(7'h49, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h0128: letter = vgd_pkg::mk_glyph(7'h49, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1ECA: letter = vgd_pkg::mk_glyph(7'h49, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00EC: letter = vgd_pkg::mk_glyph(7'h69, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00ED: letter = vgd_pkg::mk_glyph(7'h69, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EC9: letter = vgd_pkg::mk_glyph(7'h69, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h0129: letter = vgd_pkg::mk_glyph(7'h69, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1ECB: letter = vgd_pkg::mk_glyph(7'h69, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00D2: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00D3: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1ECE: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h00D5: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1ECC: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00D4: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h01A0: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_HORN, vgd_pkg::TONE_NONE);
			16'h1ED0: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h1EDA: letter = vgd_pkg::mk_glyph(7'h4F, vgd_pkg::MARK_HORN, vgd_pkg::TONE_ACUTE);
			16'h00F2: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00F3: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1ECF: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h00F5: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1ECD: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h00F4: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_NONE);
			16'h01A1: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_HORN, vgd_pkg::TONE_NONE);
			16'h1ED1: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_CIRCUMFLEX, vgd_pkg::TONE_ACUTE);
			16'h1EDB: letter = vgd_pkg::mk_glyph(7'h6F, vgd_pkg::MARK_HORN, vgd_pkg::TONE_ACUTE);
			16'h00D9: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00DA: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EE6: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h0168: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EE4: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h01AF: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_HORN, vgd_pkg::TONE_NONE);
			16'h1EE8: letter = vgd_pkg::mk_glyph(7'h55, vgd_pkg::MARK_HORN, vgd_pkg::TONE_ACUTE);
			16'h00F9: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00FA: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EE7: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h0169: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EE5: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h01B0: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_HORN, vgd_pkg::TONE_NONE);
			16'h1EE9: letter = vgd_pkg::mk_glyph(7'h75, vgd_pkg::MARK_HORN, vgd_pkg::TONE_ACUTE);
			16'h1EF2: letter = vgd_pkg::mk_glyph(7'h59, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00DD: letter = vgd_pkg::mk_glyph(7'h59, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EF6: letter = vgd_pkg::mk_glyph(7'h59, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h1EF8: letter = vgd_pkg::mk_glyph(7'h59, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EF4: letter = vgd_pkg::mk_glyph(7'h59, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			16'h1EF3: letter = vgd_pkg::mk_glyph(7'h79, vgd_pkg::MARK_NONE, vgd_pkg::TONE_GRAVE);
			16'h00FD: letter = vgd_pkg::mk_glyph(7'h79, vgd_pkg::MARK_NONE, vgd_pkg::TONE_ACUTE);
			16'h1EF7: letter = vgd_pkg::mk_glyph(7'h79, vgd_pkg::MARK_NONE, vgd_pkg::TONE_HOOK);
			16'h1EF9: letter = vgd_pkg::mk_glyph(7'h79, vgd_pkg::MARK_NONE, vgd_pkg::TONE_TILDE);
			16'h1EF5: letter = vgd_pkg::mk_glyph(7'h79, vgd_pkg::MARK_NONE, vgd_pkg::TONE_DOT);
			default:  hit = 1'b0;
		endcase
	end

	// The ranges do not overlap, so every range is checked side by side.
	always_comb begin
		range_hit   = 1'b0;
		range_glyph = vgd_pkg::mk_glyph(vgd_pkg::CH_QUESTION, vgd_pkg::MARK_NONE,
			vgd_pkg::TONE_NONE);
		off         = 16'h0000;
		for (int r = 0; r < vgd_pkg::NUM_RANGES; r++) begin
			off = cp - vgd_pkg::RANGE_START[r];
			if (off[15:3] == 13'h0000) begin
				range_hit        = 1'b1;
				range_glyph.base = vgd_pkg::RANGE_BASE[r] | {1'b0, off[0], 5'h00};
				range_glyph.mark = vgd_pkg::RANGE_MARK[r];
				range_glyph.tone = vgd_pkg::RANGE_TONE[off[2:1]];
			end
		end
	end

	always_comb begin
		if (cp[15:7] == 9'h000) begin
			glyph = vgd_pkg::mk_glyph(cp[6:0], vgd_pkg::MARK_NONE, vgd_pkg::TONE_NONE);
		end else if (hit) begin
			glyph = letter;
		end else if (range_hit) begin
			glyph = range_glyph;
		end else begin
			glyph = vgd_pkg::mk_glyph(vgd_pkg::CH_QUESTION, vgd_pkg::MARK_NONE,
				vgd_pkg::TONE_NONE);
		end
	end

endmodule

// ===== hw/rtl/utf8_vietnamese_glyph_decoder.sv =====
// Top level of the Vietnamese UTF-8 glyph decoder: input register, pending glyph and result register.
`timescale 1ns / 1ps

// Channel  Direction  Signals                     Item
// s_*      in         tvalid tready tdata tlast   one text byte; tlast ends the text
// m_*      out        tvalid tready tdata tuser   one glyph record; tuser marks unmapped
//
// An item is taken into an input register, and from there it is decoded,
// looked up and merged with the pending glyph in one pass of logic, so the
// block sustains one byte per cycle while the output is not stalled; the result
// register holds a glyph before it appears. A glyph is only released when the
// next non-combining code point, a zero byte or an end-of-text item arrives.
// Reset clears the byte assembler and drops any pending glyph and result.
// A stalled output holds the result register; an empty input register still
// takes one more byte, and then s_tready falls until the result is taken.

module utf8_vietnamese_glyph_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [6:0] glyph_base, [9:7] glyph_mark, [12:10] glyph_tone,
	                               // [28:13] source_codepoint, [31:29] zero
	output logic        m_tuser    // unmapped
);

	// Input register
	logic       valid_s1_q;
	logic [7:0] byte_s1_q;
	logic       eot_s1_q;

	// Pending glyph
	logic        pend_valid_q;
	logic [6:0]  pend_base_q;
	logic [2:0]  pend_mark_q;
	logic [2:0]  pend_tone_q;
	logic [15:0] pend_cp_q;

	// Result register
	logic        m_tvalid_q;
	logic [6:0]  out_base_q;
	logic [2:0]  out_mark_q;
	logic [2:0]  out_tone_q;
	logic [15:0] out_cp_q;
	logic        out_unmapped_q;

	logic            out_free;
	logic            adv;
	logic            is_comb;
	logic            emit;
	logic            pend_unmapped;
	vgd_pkg::asm_t   asm_res;
	vgd_pkg::glyph_t map_glyph;

	// The stage moves on whenever the result register is empty or being emptied.
	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = valid_s1_q && out_free;
	assign s_tready = !valid_s1_q || out_free;

	vgd_utf8_assembler u_asm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.text_byte   (byte_s1_q),
		.end_of_text (eot_s1_q),
		.res         (asm_res)
	);

	vgd_glyph_map u_map (
		.cp    (asm_res.cp),
		.glyph (map_glyph)
	);

	always_comb begin
		case (asm_res.cp)
			vgd_pkg::CP_COMB_GRAVE,
			vgd_pkg::CP_COMB_ACUTE,
			vgd_pkg::CP_COMB_CIRCUMFLEX,
			vgd_pkg::CP_COMB_TILDE,
			vgd_pkg::CP_COMB_BREVE,
			vgd_pkg::CP_COMB_HOOK,
			vgd_pkg::CP_COMB_HORN,
			vgd_pkg::CP_COMB_DOT: is_comb = 1'b1;
			default:              is_comb = 1'b0;
		endcase
	end

	// A held glyph leaves at the end of the text, on a zero byte or when a new glyph displaces it.
	assign emit = adv && pend_valid_q &&
		(asm_res.flush || (asm_res.complete && !is_comb));

	assign pend_unmapped = (pend_cp_q[15:7] != 9'h000) && (pend_base_q == vgd_pkg::CH_QUESTION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (s_tready) begin
			valid_s1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1_q <= s_tdata;
			eot_s1_q  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (adv) begin
			if (asm_res.flush) begin
				pend_valid_q <= 1'b0;
			end else if (asm_res.complete) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// A combining code point only edits the held glyph; with nothing held it
	// starts an unmapped glyph of its own through the map.
	always_ff @(posedge clk) begin
		if (adv && !asm_res.flush && asm_res.complete) begin
			if (pend_valid_q && is_comb) begin
				case (asm_res.cp)
					vgd_pkg::CP_COMB_GRAVE:      pend_tone_q <= vgd_pkg::TONE_GRAVE;
					vgd_pkg::CP_COMB_ACUTE:      pend_tone_q <= vgd_pkg::TONE_ACUTE;
					vgd_pkg::CP_COMB_CIRCUMFLEX: pend_mark_q <= vgd_pkg::MARK_CIRCUMFLEX;
					vgd_pkg::CP_COMB_TILDE:      pend_tone_q <= vgd_pkg::TONE_TILDE;
					vgd_pkg::CP_COMB_BREVE:      pend_mark_q <= vgd_pkg::MARK_BREVE;
					vgd_pkg::CP_COMB_HOOK:       pend_tone_q <= vgd_pkg::TONE_HOOK;
					vgd_pkg::CP_COMB_HORN:       pend_mark_q <= vgd_pkg::MARK_HORN;
					vgd_pkg::CP_COMB_DOT:        pend_tone_q <= vgd_pkg::TONE_DOT;
					default: begin
						pend_tone_q <= pend_tone_q;
					end
				endcase
			end else begin
				pend_base_q <= map_glyph.base;
				pend_mark_q <= map_glyph.mark;
				pend_tone_q <= map_glyph.tone;
				pend_cp_q   <= asm_res.cp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_base_q     <= pend_base_q;
			out_mark_q     <= pend_mark_q;
			out_tone_q     <= pend_tone_q;
			out_cp_q       <= pend_cp_q;
			out_unmapped_q <= pend_unmapped;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_cp_q, out_tone_q, out_mark_q, out_base_q};
	assign m_tuser  = out_unmapped_q;

`ifndef SYNTH
	// An unmapped glyph always carries the question mark as its base.
	a_unmapped_base: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[6:0] == vgd_pkg::CH_QUESTION)
		else $error("unmapped glyph with a base other than question mark");

	// Only a code point outside ASCII can be reported as unmapped.
	a_unmapped_cp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[28:20] != 9'h000)
		else $error("unmapped flag on an ASCII code point");

	// The end of the text leaves no glyph held.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && asm_res.flush |=> !pend_valid_q)
		else $error("glyph still held after the end of the text");

	// Back-pressure on the input only comes from a full input register behind a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1_q && m_tvalid_q && !m_tready)
		else $error("input stalled without a stalled result");

	// A result is only produced while a glyph was held.
	a_emit_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> pend_valid_q && out_free)
		else $error("result produced with no glyph held");
`endif

endmodule
